>>> sv/lkv_pkg.sv
// Package for the LRU key-value cache: payload types, cell control and constants.
`default_nettype none
package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // Command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
  } lkv_in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } lkv_out_t;

  // Per-cell update control
  typedef struct packed {
    logic shift;      // take key/value from the neighbor toward the front
    logic upd_valid;  // rewrite the valid bit
    logic valid_nxt;  // new valid bit when upd_valid is set
  } lkv_ctl_t;

endpackage
`default_nettype wire

>>> sv/lkv_cell.sv
// One slot of the recency-ordered chain: holds a key, a value and a valid bit.
`default_nettype none
module lkv_cell
  import lkv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lkv_ctl_t         ctl,
  input  wire logic [KEY_W-1:0] prev_key,
  input  wire logic [VAL_W-1:0] prev_value,
  input  wire logic [KEY_W-1:0] cmp_key,
  output logic      [KEY_W-1:0] key,
  output logic      [VAL_W-1:0] value,
  output logic                  valid,
  output logic                  hit,
  output logic      [VAL_W-1:0] sel_value
);

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             valid_r;

  // Valid bit: control state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.upd_valid) begin
      valid_r <= ctl.valid_nxt;
    end
  end

  // Payload moves one place toward the old end on a shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  // Match and gated value for the OR tree
  assign hit       = valid_r && (key_r == cmp_key);
  assign sel_value = hit ? value_r : '0;
  assign key       = key_r;
  assign value     = value_r;
  assign valid     = valid_r;

endmodule
`default_nettype wire

>>> sv/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: request register, chain of cells, result register.
//
//  channel | ports                         | moves
//  --------+-------------------------------+------------------------------------
//  in      | in_valid in_ready in_data     | request: cmd, lookup_key, store_value
//  out     | out_valid out_ready out_data  | result of a get: found, read_value
//  cfg     | cfg_wr_en cfg_wr_data         | capacity_in_use write, no wait
//
// A request is registered on acceptance and executed from the request register: all cells
// compare the key in parallel and the chain shifts one place in that same cycle.
// A get's result is registered in the output register on execution; one request per
// cycle is sustained unless a get stalls: a get waits in the request register while
// the output register holds an untaken result. Reset empties the store at once.
`default_nettype none
module lru_key_value_cache_top
  import lkv_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lkv_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lkv_out_t              out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  logic [CFG_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  lkv_in_t          req_r;
  logic             req_vld_r;
  lkv_out_t         out_data_r;
  logic             out_vld_r;

  logic                   exec;
  logic                   is_put;
  logic [ENTRIES-1:0]     hit_vec;
  logic [ENTRIES-1:0]     valid_vec;
  logic [ENTRIES-1:0]     hit_suffix;
  logic                   any_hit;
  logic [VAL_W-1:0]       hit_value;
  logic [VAL_W-1:0]       front_value;
  logic [OCC_W-1:0]       eff_cap;
  logic [OCC_W-1:0]       ins_pos;
  logic [CW-1:0]          cap_ext;

  lkv_ctl_t         ctl      [ENTRIES];
  logic [KEY_W-1:0] cell_key [ENTRIES];
  logic [VAL_W-1:0] cell_val [ENTRIES];
  logic [KEY_W-1:0] prev_key [ENTRIES];
  logic [VAL_W-1:0] prev_val [ENTRIES];
  logic [VAL_W-1:0] sel_val  [ENTRIES];

  // Handshake and execute decision
  assign is_put   = (req_r.cmd == CMD_PUT);
  assign exec     = req_vld_r && (is_put || !out_vld_r || out_ready);
  assign in_ready = !req_vld_r || exec;

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_vld_r <= 1'b1;
    end else if (exec) begin
      req_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Effective capacity: zero reads as one, saturate at ENTRIES
  assign cap_ext = CW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = OCC_W'(ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_ext);
    end
  end

  // Insert slot on a put miss; older entries past it drop out
  assign ins_pos = (occ_r >= eff_cap) ? (eff_cap - OCC_W'(1)) : occ_r;

  // Hit summary and value select
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value  = hit_value | sel_val[i];
      hit_suffix[i] = |(hit_vec >> i);
    end
  end
  assign any_hit     = |hit_vec;
  assign front_value = is_put ? VAL_W'(req_r.store_value) : hit_value;

  // Per-cell control
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].shift     = exec && (any_hit ? hit_suffix[i]
                                          : (is_put && (OCC_W'(i) <= ins_pos)));
      ctl[i].upd_valid = exec && is_put && !any_hit;
      ctl[i].valid_nxt = (OCC_W'(i) <= ins_pos);
    end
  end

  // Occupancy
  always_comb begin
    occ_nxt = occ_r;
    if (exec && is_put && !any_hit) begin
      occ_nxt = ins_pos + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Chain of cells, slot 0 most recent
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign prev_key[g] = KEY_W'(req_r.lookup_key);
      assign prev_val[g] = front_value;
    end else begin : g_link
      assign prev_key[g] = cell_key[g-1];
      assign prev_val[g] = cell_val[g-1];
    end

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[g]),
      .prev_key   (prev_key[g]),
      .prev_value (prev_val[g]),
      .cmp_key    (KEY_W'(req_r.lookup_key)),
      .key        (cell_key[g]),
      .value      (cell_val[g]),
      .valid      (valid_vec[g]),
      .hit        (hit_vec[g]),
      .sel_value  (sel_val[g])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec && !is_put) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && !is_put) begin
      out_data_r.found      <= any_hit;
      out_data_r.read_value <= any_hit ? hit_value : MISS_VALUE;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Keys are unique in the store
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  // Number of valid cells equals occupancy, and occupancy stays within ENTRIES
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == 32'(occ_r)) && (32'(occ_r) <= ENTRIES))
    else $error("valid cells disagree with occupancy");

  // An executed get always yields a result next cycle
  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec && !is_put |=> out_valid)
    else $error("get executed without a result");

  // Occupancy only changes on a put miss
  a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(exec && is_put && !any_hit) |=> $stable(occ_r))
    else $error("occupancy changed without an insert");
`endif

endmodule
`default_nettype wire

>>> dv/lru_cache_checker.sv
// Checker for the LRU key-value cache: recency-order predictor and result compare.
`timescale 1ns / 1ps
module lru_cache_checker
  import lkv_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  lkv_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  lkv_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               mismatches,
  output int               results_owed
);

  // Predicted store: index 0 is the most recently used entry
  logic [KEY_W-1:0] held_key [ENTRIES];
  logic [VAL_W-1:0] held_val [ENTRIES];
  int               held_count;
  logic [CFG_W-1:0] capacity;
  lkv_out_t         get_replies [$];

  // Shift entries 0..pos-1 one place back and put the entry at the front
  task automatic move_front(input int pos, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
    int i;
    for (i = pos; i > 0; i--) begin
      held_key[i] = held_key[i-1];
      held_val[i] = held_val[i-1];
    end
    held_key[0] = k;
    held_val[0] = v;
  endtask

  // Apply one request to the predicted store; a get owes one reply
  task automatic lru_access(input lkv_in_t req);
    int       pos;
    int       i;
    int       cap_eff;
    lkv_out_t reply;
    pos = -1;
    for (i = 0; i < held_count; i++) begin
      if (pos < 0 && held_key[i] == req.lookup_key) pos = i;
    end
    if (req.cmd == CMD_GET) begin
      if (pos >= 0) begin
        reply.found      = 1'b1;
        reply.read_value = held_val[pos];
        move_front(pos, req.lookup_key, held_val[pos]);
      end else begin
        reply.found      = 1'b0;
        reply.read_value = MISS_VALUE;
      end
      get_replies.push_back(reply);
    end else if (pos >= 0) begin
      move_front(pos, req.lookup_key, req.store_value);
    end else begin
      // zero means one, anything above the array size saturates
      cap_eff = capacity;
      if (cap_eff == 0) cap_eff = 1;
      if (cap_eff > ENTRIES) cap_eff = ENTRIES;
      // a lowered capacity drops several old entries at once here
      if (held_count >= cap_eff) held_count = cap_eff - 1;
      move_front(held_count, req.lookup_key, req.store_value);
      held_count++;
    end
  endtask

  // Sample both channels and the config port on the rising edge
  always @(posedge clk) begin
    lkv_out_t want;
    if (!rst_n) begin
      held_count = 0;
      capacity   = CAP_RESET;
      get_replies.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      // results first, so a result can never match a request of the same edge
      if (out_valid && out_ready) begin
        if (get_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result with no get pending: found=%0b value=%h",
                     out_data.found, out_data.read_value);
        end else begin
          want = get_replies.pop_front();
          if (out_data.found !== want.found || out_data.read_value !== want.read_value)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                       want.found, want.read_value, out_data.found, out_data.read_value);
          end
        end
      end
      if (in_valid && in_ready) lru_access(in_data);
    end
    results_owed = get_replies.size();
  end

endmodule

>>> dv/tb_lru_key_value_cache_top.sv
// Testbench top for the LRU key-value cache: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  lkv_in_t          in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  lkv_out_t         out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = CAP_RESET;

  int mismatches;
  int results_owed;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Keys that random requests mostly draw from, so gets hit and puts evict
  logic [KEY_W-1:0] key_pool [24];
  int               pool_used;

  lru_key_value_cache_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lru_cache_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic lkv_in_t make_request(input logic cmd, input logic [KEY_W-1:0] k,
                                           input logic [VAL_W-1:0] v);
    lkv_in_t r;
    r.cmd         = cmd;
    r.lookup_key  = k;
    r.store_value = v;
    return r;
  endfunction

  // Offer one request from a falling edge and hold it until accepted
  task automatic send_req(input lkv_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain: no request offered, every get answered, then wait out a trailing put
  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int               ph;
    int               n;
    int               k;
    int               r;
    int               eff;
    int               prev_eff;
    logic [CFG_W-1:0] cap_plan [8];
    lkv_in_t          req;

    cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd6, 5'd16, 5'd3, 5'd16};
    cap_plan[7] = CFG_W'($urandom_range(1, 31));
    for (k = 0; k < 24; k++) key_pool[k] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    pool_used = 8;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty store, key and value extremes, update, ignored get value
    send_req(make_request(CMD_GET, 32'h0000_0000, 32'h0000_0000));
    send_req(make_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff));
    send_req(make_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000));
    send_req(make_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000));
    send_req(make_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff));
    send_req(make_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h8000_0000, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h0000_0000, 32'hffff_ffff));
    send_req(make_request(CMD_GET, 32'h0000_0001, 32'h0000_0000));
    send_req(make_request(CMD_PUT, 32'h8000_0000, 32'h1234_5678));
    send_req(make_request(CMD_GET, 32'h8000_0000, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h7fff_ffff, 32'hdead_beef));
    send_req(make_request(CMD_PUT, 32'h5555_5555, 32'haaaa_aaaa));
    send_req(make_request(CMD_PUT, 32'haaaa_aaaa, 32'h5555_5555));
    send_req(make_request(CMD_GET, 32'haaaa_aaaa, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h5555_5555, 32'h0000_0000));
    send_req(make_request(CMD_GET, 32'h5555_5554, 32'h0000_0000));

    prev_eff = ENTRIES_DEF;
    for (ph = 0; ph < 8; ph++) begin
      settle();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cap_plan[ph];
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      eff = cap_plan[ph];
      if (eff == 0) eff = 1;
      if (eff > ENTRIES_DEF) eff = ENTRIES_DEF;

      // idling: none, sender only, receiver only, both lightly
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase

      // capacity dropped below what is held: old entries must still hit
      if (eff < prev_eff) begin
        for (k = 0; k < pool_used; k++)
          send_req(make_request(CMD_GET, key_pool[k], $urandom));
      end

      n = $urandom_range(0, 5);
      for (k = 0; k < n; k++) key_pool[$urandom_range(4, 23)] = $urandom;
      pool_used = eff + $urandom_range(1, 6);
      if (pool_used > 24) pool_used = 24;

      for (n = 0; n < 85; n++) begin
        r = $urandom_range(0, 99);
        req.cmd         = (r < 45) ? CMD_PUT : CMD_GET;
        req.lookup_key  = (r % 10 == 9) ? $urandom : key_pool[$urandom_range(0, pool_used - 1)];
        req.store_value = $urandom;
        send_req(req);
      end
      prev_eff = eff;
    end

    settle();
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
